FILE: design/rbsi_pkg.sv
package rbsi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // parallel epsilon register
  localparam int             EPS_W     = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

  // quotient bits resolved per divider stage
  localparam int DIV_BPS = 2;

  localparam int NUM_AXES  = 3;
  localparam int NUM_SLABS = 6;

  typedef enum logic [2:0] {
    FACE_NEG_X = 3'd0,
    FACE_POS_X = 3'd1,
    FACE_NEG_Y = 3'd2,
    FACE_POS_Y = 3'd3,
    FACE_NEG_Z = 3'd4,
    FACE_POS_Z = 3'd5
  } face_e;

  localparam face_e FACE_NONE = FACE_POS_Z;

  // control flags that ride along the divider pipeline
  typedef struct packed {
    logic                    valid;
    logic [NUM_AXES-1:0]     bounded;
    logic                    outside;
    logic [NUM_SLABS-1:0]    qneg;
  } ctrl_t;

  // result flags from slab resolution to the hit point stages
  typedef struct packed {
    logic  valid;
    logic  hit;
    face_e face;
  } res_t;

endpackage

FILE: design/rbsi_div.sv
module rbsi_div import rbsi_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF,
  localparam int NW = CW + 1,
  localparam int DW = NW + FB,
  localparam int STAGES = (DW + DIV_BPS - 1) / DIV_BPS,
  localparam int PW = STAGES * DIV_BPS
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [CW-1:0] den_i,
  output logic [PW-1:0] quo_o
);

  logic [PW-1:0] n_q [STAGES];
  logic [PW-1:0] q_q [STAGES];
  logic [CW-1:0] r_q [STAGES];
  logic [CW-1:0] d_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [PW-1:0] n_in, q_in, n_nx, q_nx;
    logic [CW-1:0] r_in, d_in, r_nx;

    if (s == 0) begin : g_first
      assign n_in = PW'({num_i, {FB{1'b0}}});
      assign q_in = '0;
      assign r_in = '0;
      assign d_in = den_i;
    end else begin : g_next
      assign n_in = n_q[s-1];
      assign q_in = q_q[s-1];
      assign r_in = r_q[s-1];
      assign d_in = d_q[s-1];
    end

    // restoring division, DIV_BPS quotient bits per stage
    always_comb begin
      logic [CW:0] r_ext;
      n_nx = n_in;
      q_nx = q_in;
      r_nx = r_in;
      for (int b = 0; b < DIV_BPS; b++) begin
        r_ext = {r_nx, n_nx[PW-1]};
        n_nx  = {n_nx[PW-2:0], 1'b0};
        if (r_ext >= {1'b0, d_in}) begin
          r_ext = r_ext - {1'b0, d_in};
          q_nx  = {q_nx[PW-2:0], 1'b1};
        end else begin
          q_nx  = {q_nx[PW-2:0], 1'b0};
        end
        r_nx = r_ext[CW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[s] <= n_nx;
      q_q[s] <= q_nx;
      r_q[s] <= r_nx;
      d_q[s] <= d_in;
    end
  end

  assign quo_o = q_q[STAGES-1];

endmodule

FILE: design/rbsi_resolve.sv
module rbsi_resolve import rbsi_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF,
  parameter int QW = 50
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_t                ctrl_i,
  input  logic [QW-1:0]        quo_i [NUM_SLABS],
  output res_t                 res_o,
  output logic signed [CW-1:0] th_o
);

  localparam logic [QW-1:0] LIM = {{(QW-1){1'b0}}, 1'b1} << (CW-1);
  localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] ONE = CW'(1) << FB;
  localparam logic [CW-1:0] MINUS_ONE = CW'(0) - ONE;

  // clamp quotients to slab times
  logic signed [CW-1:0] t_b_d [NUM_SLABS];
  logic signed [CW-1:0] t_b_q [NUM_SLABS];
  ctrl_t                ctrl_b_q;

  always_comb begin
    for (int i = 0; i < NUM_SLABS; i++) begin
      if (quo_i[i] > LIM) begin
        t_b_d[i] = ctrl_i.qneg[i] ? SMIN : SMAX;
      end else if (ctrl_i.qneg[i]) begin
        t_b_d[i] = CW'(0) - quo_i[i][CW-1:0];
      end else if (quo_i[i] == LIM) begin
        t_b_d[i] = SMAX;
      end else begin
        t_b_d[i] = quo_i[i][CW-1:0];
      end
    end
  end

  // entry and exit over bounded axes
  logic signed [CW-1:0] entry_d, exit_d, entry_q, exit_q;
  logic signed [CW-1:0] t_c_q [NUM_SLABS];
  ctrl_t                ctrl_c_q;

  always_comb begin
    logic signed [CW-1:0] n, f;
    entry_d = SMIN;
    exit_d  = SMAX;
    for (int a = 0; a < NUM_AXES; a++) begin
      n = (t_b_q[2*a] < t_b_q[2*a+1]) ? t_b_q[2*a] : t_b_q[2*a+1];
      f = (t_b_q[2*a] < t_b_q[2*a+1]) ? t_b_q[2*a+1] : t_b_q[2*a];
      if (ctrl_b_q.bounded[a]) begin
        if (n > entry_d) entry_d = n;
        if (f < exit_d)  exit_d  = f;
      end
    end
  end

  // hit decision and face
  logic                 miss;
  logic signed [CW-1:0] th_sel;
  face_e                face_d;
  res_t                 res_q;
  logic signed [CW-1:0] th_q;

  always_comb begin
    miss   = ctrl_c_q.outside || (exit_q < 0) || (entry_q > exit_q);
    th_sel = (entry_q < 0) ? exit_q : entry_q;
    face_d = FACE_NONE;
    for (int i = 0; i < NUM_SLABS; i++) begin
      if (ctrl_c_q.bounded[i/2] && (t_c_q[i] == th_sel)) face_d = face_e'(3'(i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_b_q <= '0;
      ctrl_c_q <= '0;
      res_q    <= '{valid: 1'b0, hit: 1'b0, face: FACE_NONE};
    end else begin
      ctrl_b_q    <= ctrl_i;
      ctrl_c_q    <= ctrl_b_q;
      res_q.valid <= ctrl_c_q.valid;
      res_q.hit   <= !miss;
      res_q.face  <= miss ? FACE_NONE : face_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_b_q   <= t_b_d;
    t_c_q   <= t_b_q;
    entry_q <= entry_d;
    exit_q  <= exit_d;
    th_q    <= miss ? MINUS_ONE : th_sel;
  end

  assign res_o = res_q;
  assign th_o  = th_q;

endmodule

FILE: design/rbsi_point.sv
module rbsi_point import rbsi_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  res_t                 res_i,
  input  logic signed [CW-1:0] th_i,
  input  logic signed [CW-1:0] org_i [NUM_AXES],
  input  logic signed [CW-1:0] dir_i [NUM_AXES],
  output logic                 valid_o,
  output logic                 hit_o,
  output logic signed [CW-1:0] time_o,
  output logic signed [CW-1:0] point_o [NUM_AXES],
  output logic [2:0]           face_o
);

  localparam logic [2*CW-1:0] LIM_NEG = {{CW{1'b0}}, 1'b1, {(CW-1){1'b0}}};
  localparam logic [2*CW-1:0] LIM_POS = {{(CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [CW+1:0] SMAX_X = {3'b000, {(CW-1){1'b1}}};
  localparam logic signed [CW+1:0] SMIN_X = {3'b111, {(CW-1){1'b0}}};

  // magnitude product
  logic [CW-1:0]         dmag [NUM_AXES];
  logic [CW-1:0]         tmag;
  logic [2*CW-1:0]       prod_q [NUM_AXES];
  logic [NUM_AXES-1:0]   neg_q;
  logic signed [CW-1:0]  org_e_q [NUM_AXES];
  logic signed [CW-1:0]  th_e_q;
  res_t                  res_e_q;

  always_comb begin
    tmag = th_i[CW-1] ? CW'(0) - th_i : th_i;
    for (int a = 0; a < NUM_AXES; a++) begin
      dmag[a] = dir_i[a][CW-1] ? CW'(0) - dir_i[a] : dir_i[a];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      prod_q[a]  <= dmag[a] * tmag;
      neg_q[a]   <= dir_i[a][CW-1] ^ th_i[CW-1];
      org_e_q[a] <= org_i[a];
    end
    th_e_q <= th_i;
  end

  // scale, saturate, add origin, zero on a miss
  logic signed [CW-1:0] pt_d [NUM_AXES];

  always_comb begin
    logic [2*CW-1:0]     m;
    logic signed [CW:0]  sv;
    logic signed [CW+1:0] sum;
    for (int a = 0; a < NUM_AXES; a++) begin
      m = prod_q[a] >> FB;
      if (neg_q[a]) begin
        if (m > LIM_NEG) m = LIM_NEG;
        sv = (CW+1)'(0) - m[CW:0];
      end else begin
        if (m > LIM_POS) m = LIM_POS;
        sv = m[CW:0];
      end
      sum = {{2{org_e_q[a][CW-1]}}, org_e_q[a]} + {sv[CW], sv};
      if (sum > SMAX_X)      pt_d[a] = SMAX_X[CW-1:0];
      else if (sum < SMIN_X) pt_d[a] = SMIN_X[CW-1:0];
      else                   pt_d[a] = sum[CW-1:0];
      if (!res_e_q.hit) pt_d[a] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_e_q <= '{valid: 1'b0, hit: 1'b0, face: FACE_NONE};
      valid_o <= 1'b0;
    end else begin
      res_e_q <= res_i;
      valid_o <= res_e_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o   <= res_e_q.hit;
    time_o  <= th_e_q;
    point_o <= pt_d;
    face_o  <= res_e_q.face;
  end

endmodule

FILE: design/ray_box_slab_intersect_top.sv
// ray against axis-aligned box, slab method, signed fixed point
//
// input: pulse start with one box (center, half extents) and one ray
//   (origin, direction) on the payload ports; busy is always low, so a
//   new beat may be given in every clock cycle
// output: result_valid_o is high for exactly one cycle per input beat,
//   with hit, hit time, hit point and struck face; results leave in the
//   order the beats came in and the receiver cannot hold them off
// pipeline: front stage, STAGES = ceil((COORD_WIDTH+1+FRAC_BITS)/2) divider stages
//   (default Q16.16), resolve and hit point stages; one beat per cycle sustained
// the divider stages come from the six slab dividers, which resolve two quotient
//   bits per stage; the hit point multipliers take two more stages
// config: parallel_epsilon_i is written when parallel_epsilon_we_i is high;
//   the user must write it only while no beat is in flight; the block does not enforce this
// reset: rst_ni clears all valid bits, epsilon returns to 1 lsb;
//   no clearing pass, the pipeline is usable right after reset
module ray_box_slab_intersect_top import rbsi_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] box_center_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_center_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_center_z_i,
  input  logic [COORD_WIDTH-2:0]        half_size_x_i,
  input  logic [COORD_WIDTH-2:0]        half_size_y_i,
  input  logic [COORD_WIDTH-2:0]        half_size_z_i,
  input  logic signed [COORD_WIDTH-1:0] ray_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] ray_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] ray_start_z_i,
  input  logic signed [COORD_WIDTH-1:0] ray_dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] ray_dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] ray_dir_z_i,
  // configuration
  input  logic                          parallel_epsilon_we_i,
  input  logic [EPS_W-1:0]              parallel_epsilon_i,
  // result channel
  output logic                          result_valid_o,
  output logic                          hit_o,
  output logic signed [COORD_WIDTH-1:0] hit_time_o,
  output logic signed [COORD_WIDTH-1:0] hit_point_x_o,
  output logic signed [COORD_WIDTH-1:0] hit_point_y_o,
  output logic signed [COORD_WIDTH-1:0] hit_point_z_o,
  output logic [2:0]                    hit_face_o
);

  localparam int CW     = COORD_WIDTH;
  localparam int NW     = CW + 1;
  localparam int DW     = NW + FRAC_BITS;
  localparam int STAGES = (DW + DIV_BPS - 1) / DIV_BPS;
  localparam int PW     = STAGES * DIV_BPS;
  // origin and direction wait for dividers plus three resolve stages
  localparam int SIDE   = STAGES + 3;

  assign busy = 1'b0;

  // epsilon register
  logic [EPS_W-1:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (parallel_epsilon_we_i) begin
      eps_q <= parallel_epsilon_i;
    end
  end

  // per-axis views of the payload
  logic signed [CW-1:0] c   [NUM_AXES];
  logic [CW-2:0]        h   [NUM_AXES];
  logic signed [CW-1:0] org [NUM_AXES];
  logic signed [CW-1:0] dir [NUM_AXES];

  assign c   = '{box_center_x_i, box_center_y_i, box_center_z_i};
  assign h   = '{half_size_x_i, half_size_y_i, half_size_z_i};
  assign org = '{ray_start_x_i, ray_start_y_i, ray_start_z_i};
  assign dir = '{ray_dir_x_i, ray_dir_y_i, ray_dir_z_i};

  // front stage: slab bounds, numerators, magnitudes, parallel test
  logic [NW-1:0] nmag_d [NUM_SLABS];
  logic [CW-1:0] dmag_d [NUM_AXES];
  ctrl_t         ctrl_d;

  always_comb begin
    logic signed [CW:0]   lo, hi, org_x;
    logic signed [CW+1:0] nlo, nhi, nlo_n, nhi_n;
    logic [CW-1:0]        dneg;
    ctrl_d         = '0;
    ctrl_d.valid   = start;
    for (int a = 0; a < NUM_AXES; a++) begin
      org_x = {org[a][CW-1], org[a]};
      lo    = {c[a][CW-1], c[a]} - $signed({2'b00, h[a]});
      hi    = {c[a][CW-1], c[a]} + $signed({2'b00, h[a]});
      nlo   = {lo[CW], lo} - {org_x[CW], org_x};
      nhi   = {hi[CW], hi} - {org_x[CW], org_x};
      nlo_n = (CW+2)'(0) - nlo;
      nhi_n = (CW+2)'(0) - nhi;
      nmag_d[2*a]   = nlo[CW+1] ? nlo_n[CW:0] : nlo[CW:0];
      nmag_d[2*a+1] = nhi[CW+1] ? nhi_n[CW:0] : nhi[CW:0];
      dneg      = CW'(0) - dir[a];
      dmag_d[a] = dir[a][CW-1] ? dneg : dir[a];
      ctrl_d.bounded[a]  = dmag_d[a] > CW'(eps_q);
      ctrl_d.qneg[2*a]   = nlo[CW+1] ^ dir[a][CW-1];
      ctrl_d.qneg[2*a+1] = nhi[CW+1] ^ dir[a][CW-1];
      // parallel axis with the origin outside its slab misses outright
      if (!ctrl_d.bounded[a] && ((org_x < lo) || (org_x > hi))) ctrl_d.outside = 1'b1;
    end
  end

  logic [NW-1:0]        nmag_q [NUM_SLABS];
  logic [CW-1:0]        dmag_q [NUM_AXES];
  ctrl_t                ctrl_q;
  logic signed [CW-1:0] org_q  [NUM_AXES];
  logic signed [CW-1:0] dir_q  [NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nmag_q <= nmag_d;
    dmag_q <= dmag_d;
    org_q  <= org;
    dir_q  <= dir;
  end

  // six slab dividers, low and high bound per axis
  logic [PW-1:0] quo [NUM_SLABS];

  for (genvar i = 0; i < NUM_SLABS; i++) begin : g_div
    rbsi_div #(
      .CW (CW),
      .FB (FRAC_BITS)
    ) u_div (
      .clk_i (clk_i),
      .num_i (nmag_q[i]),
      .den_i (dmag_q[i/2]),
      .quo_o (quo[i])
    );
  end

  // side lines that keep flags aligned with the dividers and ray data with the resolve stages
  ctrl_t                ctrl_line_q [STAGES];
  logic signed [CW-1:0] org_line_q  [SIDE][NUM_AXES];
  logic signed [CW-1:0] dir_line_q  [SIDE][NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAGES; k++) ctrl_line_q[k] <= '0;
    end else begin
      ctrl_line_q[0] <= ctrl_q;
      for (int k = 1; k < STAGES; k++) ctrl_line_q[k] <= ctrl_line_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    org_line_q[0] <= org_q;
    dir_line_q[0] <= dir_q;
    for (int k = 1; k < SIDE; k++) begin
      org_line_q[k] <= org_line_q[k-1];
      dir_line_q[k] <= dir_line_q[k-1];
    end
  end

  // slab times, entry and exit, hit time and face
  res_t                 res;
  logic signed [CW-1:0] th;

  rbsi_resolve #(
    .CW (CW),
    .FB (FRAC_BITS),
    .QW (PW)
  ) u_resolve (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_line_q[STAGES-1]),
    .quo_i  (quo),
    .res_o  (res),
    .th_o   (th)
  );

  // hit point from origin plus direction times hit time
  logic signed [CW-1:0] point [NUM_AXES];

  rbsi_point #(
    .CW (CW),
    .FB (FRAC_BITS)
  ) u_point (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .th_i    (th),
    .org_i   (org_line_q[SIDE-1]),
    .dir_i   (dir_line_q[SIDE-1]),
    .valid_o (result_valid_o),
    .hit_o   (hit_o),
    .time_o  (hit_time_o),
    .point_o (point),
    .face_o  (hit_face_o)
  );

  assign hit_point_x_o = point[0];
  assign hit_point_y_o = point[1];
  assign hit_point_z_o = point[2];

endmodule

FILE: sim/ray_box_slab_intersect_top_tb.sv
module ray_box_slab_intersect_top_tb;
  import rbsi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam longint ONE = 64'sd65536;
  localparam int LATENCY = 31;
  localparam int CYCLE_LIMIT = 600000;

  // one box and one ray, per axis
  typedef struct {
    logic signed [CW-1:0] center[3];
    logic [CW-2:0] half[3];
    logic signed [CW-1:0] org[3];
    logic signed [CW-1:0] dir[3];
  } ray_box_t;

  typedef struct {
    logic hit;
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] pt[3];
    face_e face;
  } hit_info_t;

  // ---------------------------------------------------------------------
  // scoreboard: slab predictor plus queue of pending hit results
  // ---------------------------------------------------------------------
  class slab_scoreboard;
    logic [EPS_W-1:0] eps;
    hit_info_t pending_hits[$];
    int mismatches;
    int hits_seen;
    int results_seen;

    function new();
      eps = EPS_RESET;
      mismatches = 0;
      hits_seen = 0;
      results_seen = 0;
    endfunction

    static function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    static function longint from_mag(longint unsigned m, bit neg);
      if (neg) return m > 64'd2147483648 ? SMIN : -longint'(m);
      return m > 64'd2147483647 ? SMAX : longint'(m);
    endfunction

    // (num << FB) / den, truncated and saturated
    static function longint slab_time(longint num, longint den);
      return from_mag((mag(num) << FB) / mag(den), (num < 0) != (den < 0));
    endfunction

    // (a * b) >> FB, truncated and saturated
    static function longint scale_dir(longint a, longint b);
      return from_mag((mag(a) * mag(b)) >> FB, (a < 0) != (b < 0));
    endfunction

    function hit_info_t predict_hit(ray_box_t rb);
      hit_info_t r;
      longint o[3], d[3], lo, hi, t[6], near_t, far_t, entry, leave, th, p;
      bit bounded[3];
      bit miss;
      entry = SMIN;
      leave = SMAX;
      miss = 0;
      for (int a = 0; a < 3; a++) begin
        o[a] = rb.org[a];
        d[a] = rb.dir[a];
        lo = longint'(rb.center[a]) - longint'({1'b0, rb.half[a]});
        hi = longint'(rb.center[a]) + longint'({1'b0, rb.half[a]});
        t[2*a] = 0;
        t[2*a+1] = 0;
        if (mag(d[a]) <= eps) begin
          // parallel axis only tests that the origin is inside the slab
          bounded[a] = 0;
          if (o[a] < lo || o[a] > hi) miss = 1;
        end else begin
          bounded[a] = 1;
          t[2*a] = slab_time(lo - o[a], d[a]);
          t[2*a+1] = slab_time(hi - o[a], d[a]);
          near_t = t[2*a] < t[2*a+1] ? t[2*a] : t[2*a+1];
          far_t = t[2*a] < t[2*a+1] ? t[2*a+1] : t[2*a];
          if (near_t > entry) entry = near_t;
          if (far_t < leave) leave = far_t;
        end
      end
      if (leave < 0 || entry > leave) miss = 1;
      r.face = FACE_NONE;
      if (miss) begin
        r.hit = 0;
        r.t = CW'(-ONE);
        foreach (r.pt[a]) r.pt[a] = '0;
        return r;
      end
      th = entry < 0 ? leave : entry;
      // last equal slab wins
      for (int i = 0; i < 6; i++)
        if (bounded[i/2] && t[i] == th) r.face = face_e'(i);
      r.hit = 1;
      r.t = CW'(th);
      for (int a = 0; a < 3; a++) begin
        p = o[a] + scale_dir(d[a], th);
        r.pt[a] = CW'(p > SMAX ? SMAX : (p < SMIN ? SMIN : p));
      end
      return r;
    endfunction

    function void note_beat(ray_box_t rb);
      pending_hits.insert(pending_hits.size(), predict_hit(rb));
    endfunction

    function void check_result(hit_info_t act);
      hit_info_t exp_r;
      bit bad;
      results_seen++;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, nothing pending");
        return;
      end
      exp_r = pending_hits.pop_front();
      bad = act.hit !== exp_r.hit || act.t !== exp_r.t || act.face !== exp_r.face;
      foreach (act.pt[a]) if (act.pt[a] !== exp_r.pt[a]) bad = 1;
      if (exp_r.hit) hits_seen++;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp hit %0b t %h pt %h %h %h face %0d",
                    " | act hit %0b t %h pt %h %h %h face %0d"},
                   exp_r.hit, exp_r.t, exp_r.pt[0], exp_r.pt[1], exp_r.pt[2], exp_r.face,
                   act.hit, act.t, act.pt[0], act.pt[1], act.pt[2], act.face);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // clock, reset, dut
  // ---------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  ray_box_t beat_q;
  logic eps_we = 1'b0;
  logic [EPS_W-1:0] eps_data = '0;
  logic result_valid_o, hit_o;
  logic signed [CW-1:0] hit_time_o, hit_point_x_o, hit_point_y_o, hit_point_z_o;
  logic [2:0] hit_face_o;

  slab_scoreboard sb = new();
  int cycles = 0;
  int beats_sent = 0;
  int eps_writes = 0;

  always #1 clk_i = ~clk_i;

  initial begin
    foreach (beat_q.center[a]) begin
      beat_q.center[a] = '0;
      beat_q.half[a] = '0;
      beat_q.org[a] = '0;
      beat_q.dir[a] = '0;
    end
  end

  ray_box_slab_intersect_top u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start                 (start),
    .busy                  (busy),
    .box_center_x_i        (beat_q.center[0]),
    .box_center_y_i        (beat_q.center[1]),
    .box_center_z_i        (beat_q.center[2]),
    .half_size_x_i         (beat_q.half[0]),
    .half_size_y_i         (beat_q.half[1]),
    .half_size_z_i         (beat_q.half[2]),
    .ray_start_x_i         (beat_q.org[0]),
    .ray_start_y_i         (beat_q.org[1]),
    .ray_start_z_i         (beat_q.org[2]),
    .ray_dir_x_i           (beat_q.dir[0]),
    .ray_dir_y_i           (beat_q.dir[1]),
    .ray_dir_z_i           (beat_q.dir[2]),
    .parallel_epsilon_we_i (eps_we),
    .parallel_epsilon_i    (eps_data),
    .result_valid_o        (result_valid_o),
    .hit_o                 (hit_o),
    .hit_time_o            (hit_time_o),
    .hit_point_x_o         (hit_point_x_o),
    .hit_point_y_o         (hit_point_y_o),
    .hit_point_z_o         (hit_point_z_o),
    .hit_face_o            (hit_face_o)
  );

  // monitor: values seen here are the ones from before the edge
  always @(posedge clk_i) begin
    hit_info_t act;
    cycles <= cycles + 1;
    if (rst_ni && start && !busy) sb.note_beat(beat_q);
    if (rst_ni && result_valid_o) begin
      act.hit = hit_o;
      act.t = hit_time_o;
      act.pt[0] = hit_point_x_o;
      act.pt[1] = hit_point_y_o;
      act.pt[2] = hit_point_z_o;
      act.face = face_e'(hit_face_o);
      sb.check_result(act);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending_hits.size());
      $display("ray_box_slab_intersect_top_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------

  // one beat, with random idle cycles before it at the given percentage
  task automatic send_beat(ray_box_t rb, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    beat_q <= rb;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    beats_sent++;
  endtask

  // hold off until every pending result is back, then let the pipe empty
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_hits.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // epsilon write, only ever from an idle pipe
  task automatic write_eps(logic [EPS_W-1:0] v);
    drain();
    eps_we <= 1'b1;
    eps_data <= v;
    @(posedge clk_i);
    eps_we <= 1'b0;
    sb.eps = v;
    eps_writes++;
    @(posedge clk_i);
  endtask

  function automatic ray_box_t axis_box(longint c, longint h, longint ox, longint oy,
                                        longint oz, longint dx, longint dy, longint dz);
    ray_box_t rb;
    foreach (rb.center[a]) begin
      rb.center[a] = CW'(c);
      rb.half[a] = (CW-1)'(h);
    end
    rb.org[0] = CW'(ox); rb.org[1] = CW'(oy); rb.org[2] = CW'(oz);
    rb.dir[0] = CW'(dx); rb.dir[1] = CW'(dy); rb.dir[2] = CW'(dz);
    return rb;
  endfunction

  function automatic logic [CW-1:0] corner_value();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return '0;
      3: return 32'h1;
      4: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // mostly aimed rays at modest boxes, plus raw noise and corner values
  function automatic ray_box_t random_beat();
    ray_box_t rb;
    int kind;
    int sh;
    int mode;
    kind = $urandom_range(99);
    sh = $urandom_range(10);
    for (int a = 0; a < 3; a++) begin
      if (kind < 65) begin
        rb.center[a] = $signed($urandom_range(2 << 20)) - (1 << 20);
        rb.half[a] = (CW-1)'($urandom_range(1 << 19));
        rb.org[a] = $signed($urandom_range(4 << 20)) - (2 << 20);
        rb.dir[a] = ((rb.center[a] - rb.org[a]) >>> sh)
                    + $signed($urandom_range(2048)) - 1024;
        // sometimes a near-parallel component, on either side of epsilon
        if ($urandom_range(9) == 0) begin
          mode = $urandom_range(2);
          rb.dir[a] = mode == 0 ? sb.eps : (mode == 1 ? -$signed({16'b0, sb.eps})
                                                      : sb.eps + 1);
        end
        if ($urandom_range(15) == 0) rb.org[a] = rb.center[a];
      end else if (kind < 88) begin
        rb.center[a] = $urandom;
        rb.half[a] = (CW-1)'($urandom);
        rb.org[a] = $urandom;
        rb.dir[a] = $urandom;
      end else begin
        rb.center[a] = corner_value();
        rb.half[a] = (CW-1)'(corner_value());
        rb.org[a] = corner_value();
        rb.dir[a] = corner_value();
      end
    end
    return rb;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin
    ray_box_t rb;
    logic [EPS_W-1:0] eps_plan[6];
    int idle_pct;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset epsilon of one lsb, unit box at the origin
    // all axes parallel with origin inside: hit time saturates high
    send_beat(axis_box(0, ONE, 0, 0, 0, 0, 0, 0), 0);
    // all axes parallel with origin outside: miss
    send_beat(axis_box(0, ONE, 2 * ONE, 0, 0, 1, -1, 0), 0);
    // each face struck head on
    send_beat(axis_box(0, ONE, -5 * ONE, 0, 0, ONE, 0, 0), 0);
    send_beat(axis_box(0, ONE, 5 * ONE, 0, 0, -ONE, 0, 0), 0);
    send_beat(axis_box(0, ONE, 0, -5 * ONE, 0, 0, ONE, 0), 0);
    send_beat(axis_box(0, ONE, 0, 5 * ONE, 0, 0, -ONE, 0), 0);
    send_beat(axis_box(0, ONE, 0, 0, -5 * ONE, 0, 0, ONE), 0);
    send_beat(axis_box(0, ONE, 0, 0, 5 * ONE, 0, 0, -ONE), 0);
    // origin inside: exit time is reported
    send_beat(axis_box(0, ONE, 0, 0, 0, ONE, 0, 0), 0);
    // exact corner: equal slab times tie, last face wins
    send_beat(axis_box(0, ONE, -5 * ONE, -5 * ONE, -5 * ONE, ONE, ONE, ONE), 0);
    // box behind the ray
    send_beat(axis_box(0, ONE, 5 * ONE, 0, 0, ONE, 0, 0), 0);
    // slabs that do not overlap
    send_beat(axis_box(0, ONE, -5 * ONE, 5 * ONE, 0, ONE, ONE, 0), 0);
    // direction exactly at epsilon is parallel, one above is not
    send_beat(axis_box(0, ONE, -5 * ONE, 0, 0, 1, 0, 0), 0);
    send_beat(axis_box(0, ONE, -5 * ONE, 0, 0, 2, 0, 0), 0);
    // tiny direction: quotient saturates
    send_beat(axis_box(0, ONE, -5 * ONE, 0, 0, 2, 0, 0), 0);
    // field extremes
    send_beat(axis_box(SMAX, SMAX, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX), 0);
    send_beat(axis_box(SMIN, SMAX, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN), 0);
    send_beat(axis_box(SMIN, 0, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN), 0);
    send_beat(axis_box(SMAX, SMAX, SMAX, SMAX, SMAX, -1, -1, -1), 0);
    send_beat(axis_box(-1, SMAX, 0, 0, 0, SMAX, SMIN, 3), 0);
    // direction times hit time saturates before the origin is added
    send_beat(axis_box(SMAX, ONE, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX), 0);

    // random phases: sender idling light-heavy-none, epsilon swept
    eps_plan[0] = '0;
    eps_plan[1] = 16'hffff;
    eps_plan[2] = 16'd1;
    eps_plan[3] = EPS_W'($urandom);
    eps_plan[4] = 16'h0100;
    eps_plan[5] = EPS_W'($urandom);
    for (int seg = 0; seg < 6; seg++) begin
      write_eps(eps_plan[seg]);
      idle_pct = seg < 2 ? 8 : (seg < 4 ? 84 : 0);
      for (int n = 0; n < 230; n++) begin
        rb = random_beat();
        send_beat(rb, idle_pct);
        // mid-phase hold-off until the pipe is empty
        if (n == 115) drain();
      end
    end
    start <= 1'b0;

    // wait out the tail
    while (sb.pending_hits.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);

    $display("sent %0d beats, checked %0d results (%0d hits), %0d epsilon writes",
             beats_sent, sb.results_seen, sb.hits_seen, eps_writes);
    $display("directed faces, ties, parallel slabs and saturation; random aimed and raw rays");
    if (sb.mismatches == 0) begin
      $display("ray_box_slab_intersect_top_tb OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("ray_box_slab_intersect_top_tb NOT OK");
    end
    $finish;
  end

endmodule
